// ===== sv/rtoc_pkg.sv =====
// rtoc_pkg: shared types and constants of the archive table-of-contents parser
// no dependencies; imported by the interfaces and all parser modules
package rtoc_pkg;

   // widths of the stream fields
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned TypeWidth   = 16;
   localparam int unsigned IdWidth     = 32;
   localparam int unsigned PosWidth    = 32;
   localparam int unsigned LenWidth    = 23;
   localparam int unsigned HdrWidth    = 22;
   localparam int unsigned StatusWidth = 2;

   // configuration register indexes
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = 16;
   localparam logic [CsrIndexWidth-1:0] CSR_FILTER_ENABLE = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_TYPE_SELECT   = 1'b1;

   // result status codes
   typedef enum logic [StatusWidth-1:0] {
      ST_DESC      = 2'd0,
      ST_END       = 2'd1,
      ST_TRUNC_HDR = 2'd2,
      ST_BAD_LEAD  = 2'd3
   } status_type;

   // lead byte class, top two bits of the lead
   typedef enum logic [1:0] {
      CLS_TYPE  = 2'b00,
      CLS_DELTA = 2'b01,
      CLS_LEN   = 2'b10,
      CLS_BAD   = 2'b11
   } lead_class_type;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 first;
      logic                 last;
   } item_type;

   typedef struct packed {
      status_type           status;
      logic [TypeWidth-1:0] res_type;
      logic [IdWidth-1:0]   res_id;
      logic [PosWidth-1:0]  payload_offset;
      logic [LenWidth-1:0]  payload_length;
      logic                 done_res;
   } result_type;

   typedef struct packed {
      logic                 filter_enable;
      logic [TypeWidth-1:0] type_select;
   } cfg_type;

endpackage

// ===== sv/rtoc_req_if.sv =====
// rtoc_req_if: valid/ready channel carrying archive stream bytes
// depends on rtoc_pkg
interface rtoc_req_if;
   import rtoc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] data_byte;
   logic                 first;
   logic                 last;

   modport source (output valid, output data_byte, output first, output last, input ready);
   modport sink (input valid, input data_byte, input first, input last, output ready);
endinterface

// rtoc_rsp_if: valid/ready channel carrying resource descriptors and status
interface rtoc_rsp_if;
   import rtoc_pkg::*;

   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [TypeWidth-1:0] res_type;
   logic [IdWidth-1:0]   res_id;
   logic [PosWidth-1:0]  payload_offset;
   logic [LenWidth-1:0]  payload_length;
   logic                 done_res;

   modport source (output valid, output status, output res_type, output res_id,
                   output payload_offset, output payload_length, output done_res,
                   input ready);
   modport sink (input valid, input status, input res_type, input res_id,
                 input payload_offset, input payload_length, input done_res,
                 output ready);
endinterface

// ===== sv/rtoc_in_reg.sv =====
// rtoc_in_reg: input register stage, holds one accepted stream byte
// depends on rtoc_pkg and rtoc_req_if
module rtoc_in_reg (
   input  logic              clock,
   input  logic              reset,
   rtoc_req_if.sink          req,
   input  logic              out_free,
   output logic              item_valid,
   output rtoc_pkg::item_type item,
   output logic              advance
);
   import rtoc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   // the held byte moves on when the result register can take its outcome
   assign advance   = valid_ff && out_free;
   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = '{data_byte: req.data_byte, first: req.first, last: req.last};
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

   // a held byte is never dropped while the result side is stalled
   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_free |=> valid_ff && $stable(item_ff))
      else $error("input stage lost a byte while stalled");

endmodule

// ===== sv/rtoc_parse.sv =====
// rtoc_parse: parser state and single-pass decode of one stream byte
// depends on rtoc_pkg
module rtoc_parse #(
   parameter int unsigned SIGNATURE_BYTES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  rtoc_pkg::item_type  item,
   input  rtoc_pkg::cfg_type   cfg,
   output logic                res_valid,
   output rtoc_pkg::result_type res
);
   import rtoc_pkg::*;

   typedef enum logic [2:0] {
      PH_SIG, PH_LEAD, PH_DELTA, PH_LEN1, PH_LEN2, PH_PAYLOAD, PH_DONE
   } phase_type;

   localparam phase_type PhaseStart = (SIGNATURE_BYTES > 0) ? PH_SIG : PH_LEAD;
   localparam logic [PosWidth-1:0] SigCount = PosWidth'(SIGNATURE_BYTES);

   phase_type            phase_ff, phase_in, phase_cur;
   logic [PosWidth-1:0]  position_ff, position_in, position_cur, pos_next;
   logic [TypeWidth-1:0] type_ff, type_in, type_cur;
   logic [IdWidth-1:0]   id_ff, id_in, id_cur;
   logic [HdrWidth-1:0]  hdr_ff, hdr_in, hdr_cur;
   logic [LenWidth-1:0]  remain_ff, remain_in, remain_cur, remain_dec;
   logic [PosWidth-1:0]  start_ff, start_in, start_cur;
   logic [ByteWidth-1:0] b;
   lead_class_type       lead_class;
   logic                 report;

   assign b          = item.data_byte;
   assign lead_class = lead_class_type'(b[7:6]);

   // state as seen by this byte: a first byte restarts the parser
   always_comb begin
      if (item.first) begin
         phase_cur    = PhaseStart;
         position_cur = '0;
         type_cur     = TypeWidth'(1);
         id_cur       = IdWidth'(1);
         hdr_cur      = '0;
         remain_cur   = '0;
         start_cur    = '0;
      end else begin
         phase_cur    = phase_ff;
         position_cur = position_ff;
         type_cur     = type_ff;
         id_cur       = id_ff;
         hdr_cur      = hdr_ff;
         remain_cur   = remain_ff;
         start_cur    = start_ff;
      end
   end

   assign pos_next   = position_cur + PosWidth'(1);
   assign remain_dec = remain_cur - LenWidth'(1);
   assign report     = !cfg.filter_enable || (type_cur == cfg.type_select);

   // decode one byte
   always_comb begin
      phase_in    = phase_ff;
      position_in = position_ff;
      type_in     = type_ff;
      id_in       = id_ff;
      hdr_in      = hdr_ff;
      remain_in   = remain_ff;
      start_in    = start_ff;
      res_valid   = 1'b0;
      res         = '{status: ST_END, done_res: 1'b1, default: '0};
      if (step) begin
         phase_in    = phase_cur;
         position_in = position_cur;
         type_in     = type_cur;
         id_in       = id_cur;
         hdr_in      = hdr_cur;
         remain_in   = remain_cur;
         start_in    = start_cur;
         if (phase_cur != PH_DONE) begin
            position_in = pos_next;
            case (phase_cur)
               PH_SIG: begin
                  if (pos_next >= SigCount) phase_in = PH_LEAD;
                  if (item.last) begin
                     res_valid = 1'b1;
                     phase_in  = PH_DONE;
                  end
               end
               PH_LEAD: begin
                  if (b == '0) begin
                     res_valid = 1'b1;
                     phase_in  = PH_DONE;
                  end else begin
                     case (lead_class)
                        CLS_TYPE: begin
                           type_in = type_cur + TypeWidth'(b);
                           id_in   = IdWidth'(1);
                           if (item.last) begin
                              res_valid = 1'b1;
                              phase_in  = PH_DONE;
                           end
                        end
                        CLS_DELTA, CLS_LEN: begin
                           if (item.last) begin
                              res_valid  = 1'b1;
                              res.status = ST_TRUNC_HDR;
                              phase_in   = PH_DONE;
                           end else begin
                              hdr_in   = HdrWidth'(b[5:0]);
                              phase_in = (lead_class == CLS_DELTA) ? PH_DELTA : PH_LEN1;
                           end
                        end
                        default: begin
                           res_valid  = 1'b1;
                           res.status = ST_BAD_LEAD;
                           phase_in   = PH_DONE;
                        end
                     endcase
                  end
               end
               PH_DELTA: begin
                  id_in    = id_cur + IdWidth'({hdr_cur[5:0], b}) + IdWidth'(1);
                  phase_in = PH_LEAD;
                  if (item.last) begin
                     res_valid = 1'b1;
                     phase_in  = PH_DONE;
                  end
               end
               PH_LEN1: begin
                  if (item.last) begin
                     res_valid  = 1'b1;
                     res.status = ST_TRUNC_HDR;
                     phase_in   = PH_DONE;
                  end else begin
                     hdr_in   = HdrWidth'({hdr_cur[5:0], b});
                     phase_in = PH_LEN2;
                  end
               end
               PH_LEN2: begin
                  if (item.last) begin
                     res_valid = 1'b1;
                     phase_in  = PH_DONE;
                  end else begin
                     remain_in = LenWidth'({hdr_cur[13:0], b}) + LenWidth'(1);
                     start_in  = pos_next;
                     phase_in  = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  remain_in = remain_dec;
                  if (remain_dec != '0) begin
                     if (item.last) begin
                        res_valid = 1'b1;
                        phase_in  = PH_DONE;
                     end
                  end else begin
                     id_in    = id_cur + IdWidth'(1);
                     phase_in = PH_LEAD;
                     if (report) begin
                        res_valid = 1'b1;
                        res = '{status:         ST_DESC,
                                res_type:       type_cur,
                                res_id:         id_cur,
                                payload_offset: start_cur,
                                payload_length: LenWidth'(position_cur - start_cur)
                                                + LenWidth'(1),
                                done_res:       item.last};
                     end else if (item.last) begin
                        res_valid = 1'b1;
                     end
                     if (item.last) phase_in = PH_DONE;
                  end
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PhaseStart;
         position_ff <= '0;
         type_ff     <= TypeWidth'(1);
         id_ff       <= IdWidth'(1);
         hdr_ff      <= '0;
         remain_ff   <= '0;
         start_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         type_ff     <= type_in;
         id_ff       <= id_in;
         hdr_ff      <= hdr_in;
         remain_ff   <= remain_in;
         start_ff    <= start_in;
      end
   end

   // a finished parse stays silent until a new archive starts
   a_silent_after_done: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_DONE && !item.first |-> !res_valid)
      else $error("result produced after end of archive");

   // every transaction that ends the parse leaves the parser done
   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res.done_res |=> phase_ff == PH_DONE)
      else $error("parse ended but parser not in done phase");

   // descriptors only come out of a completed payload
   a_desc_from_payload: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res.status == ST_DESC |->
         phase_cur == PH_PAYLOAD && res.payload_length != '0)
      else $error("descriptor outside payload completion");

endmodule

// ===== sv/rtoc_out_reg.sv =====
// rtoc_out_reg: result register driving the response channel
// depends on rtoc_pkg and rtoc_rsp_if
module rtoc_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 res_valid,
   input  rtoc_pkg::result_type res,
   output logic                 out_free,
   rtoc_rsp_if.source           rsp
);
   import rtoc_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   // free when empty or when the held result leaves this cycle
   assign out_free = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = res_valid;
         res_in   = res;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp.valid          = valid_ff;
   assign rsp.status         = res_ff.status;
   assign rsp.res_type       = res_ff.res_type;
   assign rsp.res_id         = res_ff.res_id;
   assign rsp.payload_offset = res_ff.payload_offset;
   assign rsp.payload_length = res_ff.payload_length;
   assign rsp.done_res       = res_ff.done_res;

   // load only happens into a free register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("result register overwritten while stalled");

   // status results carry zero fields and end the parse
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      valid_ff && res_ff.status != ST_DESC |->
         res_ff.done_res && res_ff.res_id == '0 && res_ff.payload_length == '0)
      else $error("status result with descriptor fields set");

endmodule

// ===== sv/resource_archive_toc_parser_core.sv =====
// resource_archive_toc_parser_core: top level of the archive toc parser
// depends on rtoc_pkg, rtoc_req_if/rtoc_rsp_if, rtoc_in_reg, rtoc_parse, rtoc_out_reg
//
//   channel  direction  handshake     carries
//   req      in         valid/ready   data_byte, first, last
//   rsp      out        valid/ready   status, res_type, res_id, payload_offset,
//                                     payload_length, done_res
//   csr      in         write enable  csr_index, csr_wdata
//
// one byte per cycle sustained while rsp is ready; an accepted byte passes
// the input register, then decode into the result register
// reset is synchronous and active high; it clears parser state and registers
// a stalled rsp holds the result and the held byte, req.ready drops while a byte is held
module resource_archive_toc_parser_core #(
   parameter int unsigned SIGNATURE_BYTES = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   rtoc_req_if.sink                            req,
   rtoc_rsp_if.source                          rsp,
   input  logic                                csr_we,
   input  logic [rtoc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [rtoc_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import rtoc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   item_type   item;
   result_type res;
   logic       item_valid, advance, out_free, res_valid;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FILTER_ENABLE: cfg_in.filter_enable = csr_wdata[0];
            CSR_TYPE_SELECT:   cfg_in.type_select   = csr_wdata[TypeWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register
   rtoc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .out_free   (out_free),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance)
   );

   // decode and parser state
   rtoc_parse #(
      .SIGNATURE_BYTES (SIGNATURE_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (item),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // result register
   rtoc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp       (rsp)
   );

   // nothing is presented in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("response valid right after reset");

   // a byte is only decoded while it is held
   a_step_needs_item: assert property (@(posedge clock) disable iff (reset)
      advance |-> item_valid)
      else $error("decode step without a held byte");

endmodule

// ===== bench/resource_archive_toc_parser_core_tb.sv =====
// self-checking bench for resource_archive_toc_parser_core: drives archive byte streams,
// predicts descriptors and status results in a scoreboard class, checks every rsp transaction
// depends on rtoc_pkg, rtoc_req_if, rtoc_rsp_if and the parser rtl
`timescale 1ns / 1ps

module resource_archive_toc_parser_core_tb;
   import rtoc_pkg::*;

   localparam int unsigned SigBytes = 4;
   localparam int SettleCycles = 6;
   localparam int PhaseBytes = 80;
   localparam int TypeWrapLeads = 1040;

   // how a random archive is brought to its end
   typedef enum int {
      END_ZERO_LEAD,
      END_ON_BOUNDARY,
      END_BAD_LEAD,
      END_CUT_HEADER,
      END_CUT_PAYLOAD,
      END_IN_SIGNATURE,
      END_NONE
   } archive_end_type;

   // scoreboard: tracks the parse of the stream and queues the results it implies
   class toc_tracker;
      typedef enum logic [2:0] {
         SCAN_SIG,
         SCAN_LEAD,
         SCAN_DELTA,
         SCAN_LEN_HI,
         SCAN_LEN_LO,
         SCAN_PAYLOAD,
         SCAN_DONE
      } scan_phase_type;

      bit                   filter_on;
      logic [TypeWidth-1:0] wanted_type;

      scan_phase_type       phase;
      logic [PosWidth-1:0]  position;
      logic [TypeWidth-1:0] type_ctr;
      logic [IdWidth-1:0]   id_ctr;
      logic [HdrWidth-1:0]  hdr;
      logic [LenWidth-1:0]  remaining;
      logic [PosWidth-1:0]  pay_start;

      result_type           due_results[$];
      int                   results_seen;
      int                   descs_seen;
      int                   errors;

      function new();
         filter_on = 1'b0;
         wanted_type = '0;
         results_seen = 0;
         descs_seen = 0;
         errors = 0;
         restart();
      endfunction

      function void restart();
         phase = (SigBytes > 0) ? SCAN_SIG : SCAN_LEAD;
         position = '0;
         type_ctr = 16'd1;
         id_ctr = 32'd1;
         hdr = '0;
         remaining = '0;
         pay_start = '0;
      endfunction

      function void set_register(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
         if (idx == CSR_FILTER_ENABLE) filter_on = data[0];
         else if (idx == CSR_TYPE_SELECT) wanted_type = data[TypeWidth-1:0];
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      // end of parse with a status only
      function void close_archive(status_type code);
         result_type r;
         r = '0;
         r.status = code;
         r.done_res = 1'b1;
         due_results.push_back(r);
         phase = SCAN_DONE;
      endfunction

      // advance the parse by one accepted byte
      function void decode_byte(item_type it);
         logic [PosWidth-1:0] pos;
         result_type desc;
         bit reported;
         if (it.first) restart();
         if (phase == SCAN_DONE) return;
         pos = position;
         position = position + 32'd1;
         case (phase)
            SCAN_SIG: begin
               if (pos + 32'd1 >= SigBytes) phase = SCAN_LEAD;
               if (it.last) close_archive(ST_END);
            end
            SCAN_LEAD: begin
               if (it.data_byte == 8'h00) begin
                  close_archive(ST_END);
               end else begin
                  case (lead_class_type'(it.data_byte[7:6]))
                     CLS_TYPE: begin
                        type_ctr = type_ctr + 16'(it.data_byte);
                        id_ctr = 32'd1;
                        if (it.last) close_archive(ST_END);
                     end
                     CLS_DELTA: begin
                        if (it.last) begin
                           close_archive(ST_TRUNC_HDR);
                        end else begin
                           hdr = 22'(it.data_byte[5:0]);
                           phase = SCAN_DELTA;
                        end
                     end
                     CLS_LEN: begin
                        if (it.last) begin
                           close_archive(ST_TRUNC_HDR);
                        end else begin
                           hdr = 22'(it.data_byte[5:0]);
                           phase = SCAN_LEN_HI;
                        end
                     end
                     default: close_archive(ST_BAD_LEAD);
                  endcase
               end
            end
            SCAN_DELTA: begin
               id_ctr = id_ctr + 32'({hdr[5:0], it.data_byte}) + 32'd1;
               phase = SCAN_LEAD;
               if (it.last) close_archive(ST_END);
            end
            SCAN_LEN_HI: begin
               if (it.last) begin
                  close_archive(ST_TRUNC_HDR);
               end else begin
                  hdr = 22'({hdr[5:0], it.data_byte});
                  phase = SCAN_LEN_LO;
               end
            end
            SCAN_LEN_LO: begin
               if (it.last) begin
                  close_archive(ST_END);
               end else begin
                  remaining = 23'({hdr[13:0], it.data_byte}) + 23'd1;
                  pay_start = position;
                  phase = SCAN_PAYLOAD;
               end
            end
            SCAN_PAYLOAD: begin
               remaining = remaining - 23'd1;
               if (remaining != 0) begin
                  if (it.last) close_archive(ST_END);
               end else begin
                  reported = 1'b0;
                  if (!filter_on || type_ctr == wanted_type) begin
                     desc.status = ST_DESC;
                     desc.res_type = type_ctr;
                     desc.res_id = id_ctr;
                     desc.payload_offset = pay_start;
                     desc.payload_length = 23'(pos - pay_start + 32'd1);
                     desc.done_res = it.last;
                     due_results.push_back(desc);
                     reported = 1'b1;
                  end
                  id_ctr = id_ctr + 32'd1;
                  phase = SCAN_LEAD;
                  if (it.last) begin
                     if (reported) phase = SCAN_DONE;
                     else close_archive(ST_END);
                  end
               end
            end
            default: phase = SCAN_DONE;
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      // compare one rsp transaction with the oldest queued result
      function void match_result(result_type got);
         result_type want;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         want = due_results.pop_front();
         results_seen++;
         if (want.status == ST_DESC) descs_seen++;
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("res_type", 32'(want.res_type), 32'(got.res_type));
         compare_field("res_id", want.res_id, got.res_id);
         compare_field("payload_offset", want.payload_offset, got.payload_offset);
         compare_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
         compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   rtoc_req_if req_if ();
   rtoc_rsp_if rsp_if ();

   toc_tracker tracker = new();

   bit tx_steady;
   bit rx_steady;
   int bytes_sent;
   int archives_sent;
   int settings_used;

   resource_archive_toc_parser_core #(
      .SIGNATURE_BYTES(SigBytes)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   // hold off the sender until every queued result has arrived
   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // one req transaction, with a random gap ahead of it
   task automatic send_byte(input logic [7:0] data, input bit first, input bit last);
      item_type it;
      int gap;
      it.data_byte = data;
      it.first = first;
      it.last = last;
      if ($urandom_range(0, 299) == 0) wait_for_results();
      gap = tx_steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= data;
      req_if.first <= first;
      req_if.last <= last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      tracker.decode_byte(it);
      bytes_sent++;
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      tracker.set_register(idx, data);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(input bit filter, input logic [TypeWidth-1:0] sel);
      wait_for_results();
      write_reg(CSR_FILTER_ENABLE, CsrDataWidth'(filter));
      write_reg(CSR_TYPE_SELECT, sel);
      settings_used++;
   endtask

   // one well-formed record, last optionally on its final byte
   task automatic send_record(input bit is_last);
      logic [7:0] b1;
      logic [7:0] b2;
      int total;
      case ($urandom_range(0, 5))
         0, 1: begin
            b1 = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 63))
                                              : 8'($urandom_range(1, 2));
            send_byte(b1, 1'b0, is_last);
         end
         2: begin
            send_byte(8'h40 | 8'($urandom_range(0, 63)), 1'b0, 1'b0);
            send_byte(rand_byte(), 1'b0, is_last);
         end
         default: begin
            b1 = ($urandom_range(0, 9) == 0) ? 8'h01 : 8'h00;
            b2 = (b1 == 8'h00) ? 8'($urandom_range(0, 23)) : rand_byte();
            total = {b1, b2} + 1;
            send_byte(8'h80, 1'b0, 1'b0);
            send_byte(b1, 1'b0, 1'b0);
            send_byte(b2, 1'b0, 1'b0);
            for (int i = 0; i < total; i++)
               send_byte(rand_byte(), 1'b0, is_last && i == total - 1);
         end
      endcase
   endtask

   // one random archive: mostly well-formed, sometimes broken or pure noise
   task automatic send_archive();
      archive_end_type ending;
      logic [5:0] hi;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] lead;
      int total;
      int cut;
      int n_rec;
      archives_sent++;
      tx_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(8, 30))
            send_byte(rand_byte(), $urandom_range(0, 19) == 0, $urandom_range(0, 9) == 0);
         return;
      end
      case ($urandom_range(0, 11))
         0, 1, 2, 3: ending = END_ZERO_LEAD;
         4, 5:       ending = END_ON_BOUNDARY;
         6:          ending = END_BAD_LEAD;
         7:          ending = END_CUT_HEADER;
         8, 11:      ending = END_CUT_PAYLOAD;
         9:          ending = END_IN_SIGNATURE;
         default:    ending = END_NONE;
      endcase

      // signature, possibly cut short
      cut = (ending == END_IN_SIGNATURE) ? $urandom_range(1, SigBytes) : SigBytes;
      for (int i = 0; i < cut; i++)
         send_byte(rand_byte(), i == 0, ending == END_IN_SIGNATURE && i == cut - 1);

      if (ending != END_IN_SIGNATURE) begin
         n_rec = $urandom_range(1, 10);
         for (int r = 0; r < n_rec; r++) send_record(ending == END_ON_BOUNDARY && r == n_rec - 1);
         case (ending)
            END_ZERO_LEAD: send_byte(8'h00, 1'b0, $urandom_range(0, 1) == 1);
            END_BAD_LEAD:
               send_byte(8'hC0 | 8'($urandom_range(0, 63)), 1'b0, $urandom_range(0, 1) == 1);
            END_CUT_HEADER: begin
               lead = ($urandom_range(0, 1) == 1) ? 8'h40 : 8'h80;
               lead = lead | 8'($urandom_range(0, 63));
               if (lead[7] && $urandom_range(0, 1) == 1) begin
                  send_byte(lead, 1'b0, 1'b0);
                  send_byte(rand_byte(), 1'b0, 1'b1);
               end else begin
                  send_byte(lead, 1'b0, 1'b1);
               end
            end
            END_CUT_PAYLOAD: begin
               hi = 6'($urandom_range(0, 63));
               b1 = rand_byte();
               b2 = rand_byte();
               // longest header now and then
               if ($urandom_range(0, 3) == 0) {hi, b1, b2} = '1;
               total = {hi, b1, b2} + 1;
               send_byte({2'b10, hi}, 1'b0, 1'b0);
               send_byte(b1, 1'b0, 1'b0);
               if (total == 1 || $urandom_range(0, 3) == 0) begin
                  send_byte(b2, 1'b0, 1'b1);
               end else begin
                  send_byte(b2, 1'b0, 1'b0);
                  cut = $urandom_range(1, (total - 1 < 6) ? total - 1 : 6);
                  for (int i = 0; i < cut; i++) send_byte(rand_byte(), 1'b0, i == cut - 1);
               end
            end
            default: ;
         endcase
      end

      // trailing bytes, ignored when the archive has already ended
      repeat ($urandom_range(0, 2)) send_byte(rand_byte(), 1'b0, $urandom_range(0, 1) == 1);
   endtask

   task automatic run_random(input int n_bytes);
      int target;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) send_archive();
   endtask

   // archive whose type counter wraps around to zero before a payload
   task automatic send_type_wrap_archive();
      archives_sent++;
      for (int i = 0; i < SigBytes; i++) send_byte(rand_byte(), i == 0, 1'b0);
      for (int i = 0; i < TypeWrapLeads; i++) send_byte(8'h3F, 1'b0, 1'b0);
      send_byte(8'h0F, 1'b0, 1'b0);
      send_byte(8'h80, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h04, 1'b0, 1'b0);
      repeat (5) send_byte(rand_byte(), 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
   endtask

   // rsp side: random stalls, then check each transaction
   initial begin : result_sink
      result_type got;
      int stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
         stall = rx_steady ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         got.status = rsp_if.status;
         got.res_type = rsp_if.res_type;
         got.res_id = rsp_if.res_id;
         got.payload_offset = rsp_if.payload_offset;
         got.payload_length = rsp_if.payload_length;
         got.done_res = rsp_if.done_res;
         tracker.match_result(got);
      end
   end

   // stimulus
   initial begin : stimulus
      logic [7:0] arch_a[20];
      logic [7:0] arch_b[6];
      // type lead, max delta, one-byte payload, small delta, 3-byte payload, zero lead
      arch_a = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h3F, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00,
                 8'hA5, 8'h40, 8'h00, 8'h80, 8'h00, 8'h02, 8'h11, 8'h22, 8'h33, 8'h00};
      // bad lead right after the signature, then a byte that must be ignored
      arch_b = '{8'h01, 8'h02, 8'h04, 8'h08, 8'hFF, 8'h12};

      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_FILTER_ENABLE;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.data_byte <= '0;
      req_if.first <= 1'b0;
      req_if.last <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed archives with reset settings
      settings_used = 1;
      foreach (arch_a[i]) send_byte(arch_a[i], i == 0, 1'b0);
      foreach (arch_b[i]) send_byte(arch_b[i], i == 0, i == 5);
      archives_sent += 2;

      // random archives across register settings
      run_random(PhaseBytes);
      apply_settings(1'b0, 16'hFFFF);
      run_random(PhaseBytes);
      apply_settings(1'b1, 16'd1);
      run_random(PhaseBytes);
      apply_settings(1'b1, 16'd2);
      run_random(PhaseBytes);
      apply_settings(1'b1, 16'hFFFF);
      run_random(PhaseBytes);
      apply_settings(1'b0, 16'h1234);
      run_random(PhaseBytes);
      apply_settings(1'b1, 16'd0);
      send_type_wrap_archive();
      run_random(PhaseBytes);

      wait_for_results();
      $display("sent %0d stream bytes in %0d archives under %0d register settings",
               bytes_sent, archives_sent, settings_used);
      $display("checked %0d results, %0d of them resource descriptors",
               tracker.results_seen, tracker.descs_seen);
      if (tracker.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
